FILE: src/pph_pkg.sv
// Package with the transaction types, mode codes and register defaults of the printer port.
package pph_pkg;

    localparam int BUSY_W = 20;
    localparam int ACK_W  = 10;
    localparam int IDLE_W = 8;
    localparam int CFG_W  = BUSY_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [2:0] MODE_DATA    = 3'd0;
    localparam logic [2:0] MODE_STROBE  = 3'd1;
    localparam logic [2:0] MODE_RESET   = 3'd2;
    localparam logic [2:0] MODE_BUSY_RD = 3'd3;
    localparam logic [2:0] MODE_ACK_RD  = 3'd4;
    localparam logic [2:0] MODE_USEC    = 3'd5;
    localparam logic [2:0] MODE_FRAME   = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_STROBE_RISING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUSY_TICKS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_TICKS     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_FRAMES   = 2'd3;

    localparam logic [BUSY_W-1:0] BUSY_TICKS_RST  = 20'd10000;
    localparam logic [ACK_W-1:0]  ACK_TICKS_RST   = 10'd10;
    localparam logic [IDLE_W-1:0] IDLE_FRAMES_RST = 8'd60;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] data_bits;
        logic [7:0] write_mask;
        logic       line_level;
    } in_item_t;

    typedef struct packed {
        logic       read_bit;
        logic       busy_line;
        logic       ack_line;
        logic [7:0] byte_out;
        logic       byte_valid;
        logic       job_start;
        logic       job_end;
        logic       job_discard;
    } out_item_t;

endpackage

FILE: src/parallel_printer_handshake_unit.sv
// Printer side of a parallel port handshake: latch, strobe, busy/ack timers and job tracking.
// A transaction's result is registered in the result register, or in the skid register while the output stalls.
// Throughput: one transaction per cycle while in_stall is low; the state update is a single pass of logic.
// A two-entry output buffer (result register plus skid register) lets input continue
// for one more transaction while the output side stalls; input stalls only while the skid is full.
// Reset: rst_n is asynchronous and active low; all state but the output data registers takes its reset values.
module parallel_printer_handshake_unit
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  pph_pkg::in_item_t                    in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output pph_pkg::out_item_t                   out_data,
    input  logic                                 cfg_write,
    input  logic [pph_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pph_pkg::CFG_W-1:0]            cfg_data
);

    // Configuration registers.
    logic                        strobe_rising_reg;
    logic [pph_pkg::BUSY_W-1:0]  busy_ticks_reg;
    logic [pph_pkg::ACK_W-1:0]   ack_ticks_reg;
    logic [pph_pkg::IDLE_W-1:0]  idle_frames_reg;

    // Handshake state.
    logic [7:0]                  data_latch_reg,   data_latch_next;
    logic                        data_present_reg, data_present_next;
    logic                        strobe_level_reg, strobe_level_next;
    logic                        reset_level_reg,  reset_level_next;
    logic                        busy_flag_reg,    busy_flag_next;
    logic                        ack_flag_reg,     ack_flag_next;
    logic [pph_pkg::BUSY_W-1:0]  busy_left_reg,    busy_left_next;
    logic [pph_pkg::ACK_W-1:0]   ack_left_reg,     ack_left_next;
    logic [pph_pkg::IDLE_W-1:0]  idle_left_reg,    idle_left_next;
    logic                        job_open_reg,     job_open_next;
    logic [1:0]                  job_bytes_reg,    job_bytes_next;

    // Output buffering.
    logic                        main_valid_reg;
    logic                        skid_valid_reg;
    pph_pkg::out_item_t          main_data_reg;
    pph_pkg::out_item_t          skid_data_reg;
    pph_pkg::out_item_t          result;

    logic in_accept;
    logic out_take;
    logic strobe_edge;

    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;
    assign out_take  = main_valid_reg && !out_stall;

    // Configuration registers; the host must write them only while no transaction is in flight (not enforced).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_rising_reg <= 1'b0;
            busy_ticks_reg    <= pph_pkg::BUSY_TICKS_RST;
            ack_ticks_reg     <= pph_pkg::ACK_TICKS_RST;
            idle_frames_reg   <= pph_pkg::IDLE_FRAMES_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                pph_pkg::REG_STROBE_RISING: strobe_rising_reg <= cfg_data[0];
                pph_pkg::REG_BUSY_TICKS:    busy_ticks_reg    <= cfg_data;
                pph_pkg::REG_ACK_TICKS:     ack_ticks_reg     <= cfg_data[pph_pkg::ACK_W-1:0];
                pph_pkg::REG_IDLE_FRAMES:   idle_frames_reg   <= cfg_data[pph_pkg::IDLE_W-1:0];
                default: ;
            endcase
        end
    end

    // One pass over the accepted transaction: next state and the result it produces.
    always_comb
    begin
        data_latch_next   = data_latch_reg;
        data_present_next = data_present_reg;
        strobe_level_next = strobe_level_reg;
        reset_level_next  = reset_level_reg;
        busy_flag_next    = busy_flag_reg;
        ack_flag_next     = ack_flag_reg;
        busy_left_next    = busy_left_reg;
        ack_left_next     = ack_left_reg;
        idle_left_next    = idle_left_reg;
        job_open_next     = job_open_reg;
        job_bytes_next    = job_bytes_reg;
        result            = '0;
        strobe_edge       = strobe_rising_reg ? (!strobe_level_reg && in_data.line_level)
                                              : (strobe_level_reg && !in_data.line_level);

        unique case (in_data.mode)
            pph_pkg::MODE_DATA:
            begin
                data_latch_next   = (data_latch_reg & ~in_data.write_mask)
                                  | (in_data.data_bits & in_data.write_mask);
                data_present_next = 1'b1;
            end
            pph_pkg::MODE_STROBE:
            begin
                strobe_level_next = in_data.line_level;
                if (strobe_edge && data_present_reg)
                begin
                    // The first byte opens a job; the byte count saturates at two.
                    if (!job_open_reg)
                    begin
                        job_open_next    = 1'b1;
                        job_bytes_next   = 2'd1;
                        result.job_start = 1'b1;
                    end
                    else if (job_bytes_reg < 2'd2)
                    begin
                        job_bytes_next = job_bytes_reg + 2'd1;
                    end
                    result.byte_out   = data_latch_reg;
                    result.byte_valid = 1'b1;
                    busy_left_next    = busy_ticks_reg;
                    busy_flag_next    = 1'b1;
                    idle_left_next    = idle_frames_reg;
                end
            end
            pph_pkg::MODE_RESET:
            begin
                if (reset_level_reg && !in_data.line_level)
                begin
                    // A falling reset line closes the job and stops every timer.
                    if (job_open_reg)
                    begin
                        result.job_end     = 1'b1;
                        result.job_discard = (job_bytes_reg < 2'd2);
                    end
                    job_open_next  = 1'b0;
                    job_bytes_next = 2'd0;
                    idle_left_next = '0;
                    busy_flag_next = 1'b0;
                    busy_left_next = '0;
                    ack_left_next  = '0;
                    ack_flag_next  = 1'b1;
                end
                reset_level_next = in_data.line_level;
            end
            pph_pkg::MODE_BUSY_RD:
            begin
                if (busy_flag_reg)
                begin
                    if (ack_ticks_reg != '0)
                    begin
                        ack_left_next = ack_ticks_reg;
                        ack_flag_next = 1'b0;
                    end
                    busy_flag_next  = 1'b0;
                    busy_left_next  = '0;
                    result.read_bit = 1'b1;
                end
            end
            pph_pkg::MODE_ACK_RD:
            begin
                result.read_bit = ack_flag_reg;
            end
            pph_pkg::MODE_USEC:
            begin
                // The ack timer steps first so that a pulse started by busy falling
                // on this same tick keeps its full length.
                if (ack_left_reg != '0)
                begin
                    ack_left_next = ack_left_reg - pph_pkg::ACK_W'(1);
                    if (ack_left_reg == pph_pkg::ACK_W'(1))
                    begin
                        ack_flag_next = 1'b1;
                    end
                end
                if (busy_left_reg != '0)
                begin
                    busy_left_next = busy_left_reg - pph_pkg::BUSY_W'(1);
                    if (busy_left_reg == pph_pkg::BUSY_W'(1))
                    begin
                        if (busy_flag_reg && ack_ticks_reg != '0)
                        begin
                            ack_left_next = ack_ticks_reg;
                            ack_flag_next = 1'b0;
                        end
                        busy_flag_next = 1'b0;
                    end
                end
            end
            pph_pkg::MODE_FRAME:
            begin
                if (idle_left_reg != '0)
                begin
                    idle_left_next = idle_left_reg - pph_pkg::IDLE_W'(1);
                    if (idle_left_reg == pph_pkg::IDLE_W'(1))
                    begin
                        if (job_open_reg)
                        begin
                            result.job_end     = 1'b1;
                            result.job_discard = (job_bytes_reg < 2'd2);
                        end
                        job_open_next  = 1'b0;
                        job_bytes_next = 2'd0;
                    end
                end
            end
            default: ;
        endcase

        result.busy_line = busy_flag_next;
        result.ack_line  = ack_flag_next;
    end

    // State advances only on an accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_latch_reg   <= 8'd0;
            data_present_reg <= 1'b0;
            strobe_level_reg <= 1'b1;
            reset_level_reg  <= 1'b0;
            busy_flag_reg    <= 1'b0;
            ack_flag_reg     <= 1'b1;
            busy_left_reg    <= '0;
            ack_left_reg     <= '0;
            idle_left_reg    <= '0;
            job_open_reg     <= 1'b0;
            job_bytes_reg    <= 2'd0;
        end
        else if (in_accept)
        begin
            data_latch_reg   <= data_latch_next;
            data_present_reg <= data_present_next;
            strobe_level_reg <= strobe_level_next;
            reset_level_reg  <= reset_level_next;
            busy_flag_reg    <= busy_flag_next;
            ack_flag_reg     <= ack_flag_next;
            busy_left_reg    <= busy_left_next;
            ack_left_reg     <= ack_left_next;
            idle_left_reg    <= idle_left_next;
            job_open_reg     <= job_open_next;
            job_bytes_reg    <= job_bytes_next;
        end
    end

    // Output buffer control: the skid entry always drains into the result register first.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_take)
            begin
                main_valid_reg <= skid_valid_reg || in_accept;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= main_valid_reg || in_accept;
                skid_valid_reg <= skid_valid_reg || (in_accept && main_valid_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take && skid_valid_reg)
        begin
            main_data_reg <= skid_data_reg;
        end
        else if (in_accept && (!main_valid_reg || out_take))
        begin
            main_data_reg <= result;
        end
        if (in_accept && main_valid_reg && !out_take)
        begin
            skid_data_reg <= result;
        end
    end

`ifndef SYNTHESIS
    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held while result register is empty");

    a_ack_low_timed: assert property (@(posedge clk) disable iff (!rst_n)
        !ack_flag_reg |-> (ack_left_reg != '0))
        else $error("ack is low with its timer stopped");

    a_busy_timer_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_left_reg != '0) |-> busy_flag_reg)
        else $error("busy timer running while busy is low");

    a_closed_job_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !job_open_reg |-> (job_bytes_reg == 2'd0))
        else $error("byte count kept after job closed");

    a_discard_with_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.job_discard) |-> out_data.job_end)
        else $error("discard flagged without job end");
`endif

endmodule
